@@ hw/rtl/led_pixel_current_limit_encoder_unit_defines.svh @@
// Assertion helpers for the encoder datapath RTL (lpcle_dp).
// They expect clk and rst_n in the scope of use.
`ifndef LED_PIXEL_CURRENT_LIMIT_ENCODER_UNIT_DEFINES_SVH
`define LED_PIXEL_CURRENT_LIMIT_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LPCLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPCLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lpcle_pkg.sv @@
package lpcle_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_ACC,
    S_EMIT,
    S_EST,
    S_CMP,
    S_DIV
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_ACC,
    OP_SHIFT,
    OP_EST,
    OP_DIV_START,
    OP_SCALE_UP,
    OP_HALVE_ONE,
    OP_HALVE_DIV
  } dp_op_t;

  typedef enum logic [1:0] {
    CH_GREEN,
    CH_RED,
    CH_BLUE
  } ch_t;

  typedef enum logic [1:0] {
    PH_GAIN,
    PH_TRIM,
    PH_LEVEL,
    PH_SCALE
  } mul_ph_t;

  typedef enum logic [1:0] {
    REG_OUTPUT_GAIN,
    REG_CHANNEL_FULL_CURRENT,
    REG_IDLE_CURRENT_PER_LED,
    REG_FRAME_CURRENT_BUDGET
  } cfg_reg_t;

  typedef struct packed {
    dp_op_t  op;
    ch_t     ch;
    mul_ph_t ph;
  } cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic frame_end;
    logic last_sym;
    logic over_budget;
    logic can_div;
    logic div_done;
  } sts_t;

  localparam logic [16:0] SCALE_ONE   = 17'd65536;
  localparam logic [16:0] SCALE_FLOOR = 17'd3277;
  localparam logic [16:0] SCALE_STEP  = 17'd3277;
  localparam logic [13:0] TOTAL_MAX   = 14'd16383;
  localparam logic [3:0]  TICKS_LONG  = 4'd8;
  localparam logic [3:0]  TICKS_SHORT = 4'd4;
  localparam logic [4:0]  LAST_SYM    = 5'd23;
  localparam logic [3:0]  MUL_LAST    = 4'd11;

  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 26;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

endpackage

@@ hw/rtl/led_pixel_current_limit_encoder_unit.sv @@
// Serial RGB LED pixel encoder with frame current limiting.
// Input stream: one beat per pixel; in_tlast marks the last pixel of a frame.
// Output stream: 24 symbol beats per pixel in range (green, red, blue, MSB first);
//   out_tlast marks the final symbol of a frame. A pixel index at or above LED_COUNT
//   gives no beats.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index at the clock edge
//   (0 output gain, 1 channel full current, 2 idle current per LED, 3 frame budget);
//   write only while the block is idle.
// Sequence: one pixel at a time. After the input beat the pixel passes a dispatch
//   state, four steps per channel on the shared scaling multiplier and an
//   accumulate state before its first symbol is valid. On a frame end the scale
//   update runs an estimate and a compare state, and when over budget with a nonzero
//   code total and the budget above the idle current also the bit-serial divider.
// Reset (rst_n low, synchronous): registers to their defaults, frame scale to 1.0,
//   code total to zero.
// A stalled receiver holds the current symbol; no new pixel is taken until the
//   last symbol of the current one has been accepted.
module led_pixel_current_limit_encoder_unit
  import lpcle_pkg::*;
#(
  parameter int LED_COUNT = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] pixel_index, [15:8] base_red, [23:16] base_green, [31:24] base_blue,
  // [47:32] level, [56:48] pixel_trim, [63:57] zero
  input  logic [63:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] bit_value, [4:1] high_ticks, [8:5] low_ticks, [13:9] symbol_number,
  // [14] last_of_pixel, [15] zero
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cmd_t       cmd;
  sts_t       sts;
  logic       bit_value;
  logic [3:0] high_ticks;
  logic [3:0] low_ticks;
  logic [4:0] symbol_number;
  logic       last_of_pixel;

  lpcle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lpcle_dp #(
    .LED_COUNT (LED_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_pixel_index    (in_tdata[7:0]),
    .in_base_red       (in_tdata[15:8]),
    .in_base_green     (in_tdata[23:16]),
    .in_base_blue      (in_tdata[31:24]),
    .in_level          (in_tdata[47:32]),
    .in_pixel_trim     (in_tdata[56:48]),
    .in_frame_end      (in_tlast),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_bit_value     (bit_value),
    .out_high_ticks    (high_ticks),
    .out_low_ticks     (low_ticks),
    .out_symbol_number (symbol_number),
    .out_last_of_pixel (last_of_pixel),
    .out_last_of_frame (out_tlast)
  );

  assign out_tdata = {1'b0, last_of_pixel, symbol_number, low_ticks, high_ticks, bit_value};

endmodule

@@ hw/rtl/lpcle_div.sv @@
module lpcle_div
  import lpcle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quot
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_diff;
  logic                 ge;

  // Restoring division, one quotient bit per cycle; num_r turns into the quotient.
  always_comb begin
    rem_sh   = {rem_r, num_r[DIV_NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    ge       = rem_sh >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_NUM_W-2:0], ge};
      rem_nxt = ge ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

@@ hw/rtl/lpcle_ctrl.sv @@
module lpcle_ctrl
  import lpcle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts.idx_ok)         state_nxt = S_MUL;
        else if (sts.frame_end) state_nxt = S_EST;
        else                    state_nxt = S_IDLE;
        step_nxt = '0;
      end
      S_MUL: begin
        step_nxt = step_r + 1'b1;
        if (step_r == MUL_LAST) state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_tready && sts.last_sym) state_nxt = sts.frame_end ? S_EST : S_IDLE;
      end
      S_EST: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = (sts.over_budget && sts.can_div) ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd.op     = OP_NONE;
    cmd.ch     = ch_t'(step_r[3:2]);
    cmd.ph     = mul_ph_t'(step_r[1:0]);
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_LOAD;
      end
      S_DISPATCH: cmd.op = OP_NONE;
      S_MUL:      cmd.op = OP_MUL;
      S_ACC:      cmd.op = OP_ACC;
      S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) cmd.op = OP_SHIFT;
      end
      S_EST: cmd.op = OP_EST;
      S_CMP: begin
        if (!sts.over_budget) cmd.op = OP_SCALE_UP;
        else if (sts.can_div) cmd.op = OP_DIV_START;
        else                  cmd.op = OP_HALVE_ONE;
      end
      S_DIV: begin
        if (sts.div_done) cmd.op = OP_HALVE_DIV;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

@@ hw/rtl/lpcle_dp.sv @@
`include "led_pixel_current_limit_encoder_unit_defines.svh"

module lpcle_dp
  import lpcle_pkg::*;
#(
  parameter int LED_COUNT = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  in_pixel_index,
  input  logic [7:0]  in_base_red,
  input  logic [7:0]  in_base_green,
  input  logic [7:0]  in_base_blue,
  input  logic [15:0] in_level,
  input  logic [8:0]  in_pixel_trim,
  input  logic        in_frame_end,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output logic        out_bit_value,
  output logic [3:0]  out_high_ticks,
  output logic [3:0]  out_low_ticks,
  output logic [4:0]  out_symbol_number,
  output logic        out_last_of_pixel,
  output logic        out_last_of_frame
);

  localparam logic [7:0] LedCnt = 8'(LED_COUNT);

  // configuration
  logic [15:0] gain_r, gain_nxt;
  logic [11:0] cfc_r, cfc_nxt;
  logic [11:0] idle_r, idle_nxt;
  logic [15:0] budget_r, budget_nxt;

  // frame state
  logic [16:0] scale_r, scale_nxt;
  logic [13:0] total_r, total_nxt;
  logic [4:0]  sym_cnt_r, sym_cnt_nxt;
  logic        fend_r, fend_nxt;
  logic        idx_ok_r, idx_ok_nxt;

  // pixel payload
  logic [7:0]  red_r, green_r, blue_r;
  logic [15:0] level_r;
  logic [8:0]  trim_r;
  logic [49:0] acc_r, acc_nxt;
  logic [23:0] codes_r, codes_nxt;
  logic [25:0] lit_r, lit_nxt;
  logic [19:0] quiet_r, quiet_nxt;

  logic [32:0] mul_a;
  logic [16:0] mul_b;
  logic [49:0] prod;
  logic [7:0]  color;
  logic [10:0] rnd;
  logic [7:0]  code;
  logic [14:0] sum;
  logic [27:0] quiet255;
  logic [28:0] est255;
  logic [23:0] budget255;
  logic        over_budget;
  logic        can_div;
  logic [15:0] headroom;
  logic [23:0] head255;
  logic        div_start;
  logic        div_done;
  logic [DIV_NUM_W-1:0] quot;
  logic [17:0] target;
  logic [18:0] half_sum;
  logic [17:0] half;
  logic [17:0] step_sum;

  always_comb begin
    unique case (cmd.ch)
      CH_GREEN: color = green_r;
      CH_RED:   color = red_r;
      default:  color = blue_r;
    endcase
    unique case (cmd.ph)
      PH_GAIN: begin
        mul_a = {25'b0, color};
        mul_b = {1'b0, gain_r};
      end
      PH_TRIM: begin
        mul_a = acc_r[32:0];
        mul_b = {8'b0, trim_r};
      end
      PH_LEVEL: begin
        mul_a = acc_r[32:0];
        mul_b = {1'b0, level_r};
      end
      default: begin
        mul_a = acc_r[48:16];
        mul_b = scale_r;
      end
    endcase
    prod = {17'b0, mul_a} * {33'b0, mul_b};
    rnd  = {1'b0, prod[49:40]} + {10'b0, prod[39]};
    code = (|rnd[10:8]) ? 8'hFF : rnd[7:0];
  end

  always_comb begin
    sum = {1'b0, total_r} + {7'b0, codes_r[23:16]} + {7'b0, codes_r[15:8]}
        + {7'b0, codes_r[7:0]};
    quiet255  = {quiet_r, 8'b0} - {8'b0, quiet_r};
    est255    = {3'b0, lit_r} + {1'b0, quiet255};
    budget255 = {budget_r, 8'b0} - {8'b0, budget_r};
    over_budget = est255 > {5'b0, budget255};
    can_div   = ({4'b0, budget_r} > quiet_r) && (lit_r != '0);
    headroom  = budget_r - quiet_r[15:0];
    head255   = {headroom, 8'b0} - {8'b0, headroom};
    div_start = cmd.op == OP_DIV_START;

    if (cmd.op == OP_HALVE_ONE)  target = {1'b0, SCALE_ONE};
    else if (|quot[DIV_NUM_W-1:17]) target = 18'h20000;
    else                         target = {1'b0, quot[16:0]};
    half_sum = {2'b0, scale_r} + {1'b0, target};
    half     = half_sum[18:1];
    step_sum = {1'b0, scale_r} + {1'b0, SCALE_STEP};
  end

  always_comb begin
    gain_nxt    = gain_r;
    cfc_nxt     = cfc_r;
    idle_nxt    = idle_r;
    budget_nxt  = budget_r;
    scale_nxt   = scale_r;
    total_nxt   = total_r;
    sym_cnt_nxt = sym_cnt_r;
    fend_nxt    = fend_r;
    idx_ok_nxt  = idx_ok_r;
    acc_nxt     = acc_r;
    codes_nxt   = codes_r;
    lit_nxt     = lit_r;
    quiet_nxt   = quiet_r;

    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OUTPUT_GAIN:          gain_nxt   = cfg_wdata;
        REG_CHANNEL_FULL_CURRENT: cfc_nxt    = cfg_wdata[11:0];
        REG_IDLE_CURRENT_PER_LED: idle_nxt   = cfg_wdata[11:0];
        REG_FRAME_CURRENT_BUDGET: budget_nxt = cfg_wdata;
        default:                  gain_nxt   = gain_r;
      endcase
    end

    case (cmd.op) inside
      OP_LOAD: begin
        idx_ok_nxt  = in_pixel_index < LedCnt;
        fend_nxt    = in_frame_end;
        sym_cnt_nxt = '0;
      end
      OP_MUL: begin
        acc_nxt = prod;
        if (cmd.ph == PH_SCALE) begin
          unique case (cmd.ch)
            CH_GREEN: codes_nxt[23:16] = code;
            CH_RED:   codes_nxt[15:8]  = code;
            default:  codes_nxt[7:0]   = code;
          endcase
        end
      end
      OP_ACC: begin
        total_nxt = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[13:0];
      end
      OP_SHIFT: begin
        codes_nxt   = {codes_r[22:0], 1'b0};
        sym_cnt_nxt = (sym_cnt_r == LAST_SYM) ? '0 : sym_cnt_r + 1'b1;
      end
      OP_EST: begin
        lit_nxt   = {12'b0, total_r} * {14'b0, cfc_r};
        quiet_nxt = {12'b0, LedCnt} * {8'b0, idle_r};
      end
      OP_SCALE_UP: begin
        if (scale_r < SCALE_ONE)
          scale_nxt = (step_sum > {1'b0, SCALE_ONE}) ? SCALE_ONE : step_sum[16:0];
        total_nxt = '0;
      end
      OP_HALVE_ONE, OP_HALVE_DIV: begin
        if (half > {1'b0, SCALE_ONE})        scale_nxt = SCALE_ONE;
        else if (half < {1'b0, SCALE_FLOOR}) scale_nxt = SCALE_FLOOR;
        else                                 scale_nxt = half[16:0];
        total_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= 16'd65535;
      cfc_r     <= 12'd320;
      idle_r    <= 12'd16;
      budget_r  <= 16'd8000;
      scale_r   <= SCALE_ONE;
      total_r   <= '0;
      sym_cnt_r <= '0;
      fend_r    <= 1'b0;
      idx_ok_r  <= 1'b0;
    end else begin
      gain_r    <= gain_nxt;
      cfc_r     <= cfc_nxt;
      idle_r    <= idle_nxt;
      budget_r  <= budget_nxt;
      scale_r   <= scale_nxt;
      total_r   <= total_nxt;
      sym_cnt_r <= sym_cnt_nxt;
      fend_r    <= fend_nxt;
      idx_ok_r  <= idx_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      red_r   <= in_base_red;
      green_r <= in_base_green;
      blue_r  <= in_base_blue;
      level_r <= in_level;
      trim_r  <= in_pixel_trim;
    end
    acc_r   <= acc_nxt;
    codes_r <= codes_nxt;
    lit_r   <= lit_nxt;
    quiet_r <= quiet_nxt;
  end

  lpcle_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({head255, 16'b0}),
    .den   (lit_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign sts.idx_ok      = idx_ok_r;
  assign sts.frame_end   = fend_r;
  assign sts.last_sym    = sym_cnt_r == LAST_SYM;
  assign sts.over_budget = over_budget;
  assign sts.can_div     = can_div;
  assign sts.div_done    = div_done;

  assign out_bit_value     = codes_r[23];
  assign out_high_ticks    = codes_r[23] ? TICKS_LONG : TICKS_SHORT;
  assign out_low_ticks     = codes_r[23] ? TICKS_SHORT : TICKS_LONG;
  assign out_symbol_number = sym_cnt_r;
  assign out_last_of_pixel = sym_cnt_r == LAST_SYM;
  assign out_last_of_frame = (sym_cnt_r == LAST_SYM) && fend_r;

  `LPCLE_ASSERT_IMP(a_scale_range, 1'b1,
                    (scale_r >= SCALE_FLOOR) && (scale_r <= SCALE_ONE),
                    "frame scale left its range")
  `LPCLE_ASSERT_NXT(a_total_clear,
                    (cmd.op == OP_SCALE_UP) || (cmd.op == OP_HALVE_ONE) || (cmd.op == OP_HALVE_DIV),
                    total_r == '0, "code total not cleared after frame update")
  `LPCLE_ASSERT_IMP(a_sym_range, 1'b1, sym_cnt_r <= LAST_SYM, "symbol counter overran")

endmodule
